@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the move machine executor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

@@ src/mmie_pkg.sv @@
// Types and constants of the move machine instruction executor.
package mmie_pkg;

    localparam int unsigned IN_W  = 24;
    localparam int unsigned OUT_W = 72;

    // special opcodes
    localparam logic [7:0] OP_JMP = 8'h07;
    localparam logic [7:0] OP_SEG = 8'h0C;
    localparam logic [7:0] OP_JZ  = 8'h17;
    localparam logic [7:0] OP_NOP = 8'hFF;

    localparam logic [7:0] ALU_SUB_SEL = 8'h01;
    localparam logic [7:0] COP_ID      = 8'hAA;
    localparam logic [7:0] HOST_STATUS = 8'h01;
    localparam logic [7:0] WIN_MASK    = 8'hF8;

    // move sources
    localparam logic [3:0] SRC_IMM   = 4'h0;
    localparam logic [3:0] SRC_ALU   = 4'h1;
    localparam logic [3:0] SRC_MEM   = 4'h3;
    localparam logic [3:0] SRC_AUDIO = 4'h4;

    // move destinations
    localparam logic [3:0] DST_A     = 4'h1;
    localparam logic [3:0] DST_PL    = 4'h2;
    localparam logic [3:0] DST_PH    = 4'h3;
    localparam logic [3:0] DST_B     = 4'h6;
    localparam logic [3:0] DST_MEM   = 4'h8;
    localparam logic [3:0] DST_AUDIO = 4'hA;

    // window segments and indexes
    localparam logic [2:0] SEG_HOST     = 3'd3;
    localparam logic [2:0] SEG_COP      = 3'd4;
    localparam logic [2:0] HOST_IDX_OUT = 3'd0;
    localparam logic [2:0] HOST_IDX_IN  = 3'd1;
    localparam logic [2:0] COP_IDX_ID   = 3'd0;
    localparam logic [2:0] COP_IDX_DATA = 3'd2;
    localparam logic [2:0] COP_IDX_CMD  = 3'd3;
    localparam logic [2:0] COP_IDX_RES  = 3'd5;

    // visible state after one instruction, last field in the low bits
    typedef struct packed {
        logic [7:0]  host_out_value;
        logic [7:0]  audio_value;
        logic [2:0]  segment_value;
        logic [7:0]  pointer_high;
        logic [7:0]  pointer_low;
        logic [7:0]  b_value;
        logic [7:0]  a_value;
        logic [15:0] next_pc;
    } res_t;

    // what the executing instruction does to the address of the next one
    typedef struct packed {
        logic writes_addr;
    } hz_t;

endpackage

@@ src/move_machine_instruction_executor_top.sv @@
// Move machine instruction executor: one instruction request in, one state request out.
//
// Input channel s_*: tdata = instruction (16 bits), host_in (8 bits). The
// instruction is the word fetched at the last next_pc sent out.
// Output channel m_*: tdata = next_pc, a_value, b_value, pointer_low,
// pointer_high, segment_value, audio_value, host_out_value, zero padded.
// An accepted request has its memory byte read at the accepting edge, is
// executed once the output register is free and lands in the output
// register at that edge, which raises m_tvalid.
// Throughput is one instruction per cycle while the output drains. A read of
// memory or a window is held back while an instruction that changes the
// pointer or segment is executing, since the memory read port takes its address at acceptance.
// A memory write followed by a read of the same byte is forwarded.
// When m_tready is low the output register holds, the executing instruction
// waits behind it and s_tready drops until the output drains.
// Reset clears all machine registers and empties the pipeline; data memory is
// not cleared and must be written before it is read.
`include "assert_macros.svh"

module move_machine_instruction_executor_top #(
    parameter int unsigned MEM_DEPTH = 524288
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [mmie_pkg::IN_W-1:0]  s_tdata,   // instruction[15:0], host_in[23:16]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [mmie_pkg::OUT_W-1:0] m_tdata    // next_pc[15:0], a_value[23:16],
                                                  // b_value[31:24], pointer_low[39:32],
                                                  // pointer_high[47:40], segment_value[50:48],
                                                  // audio_value[58:51], host_out_value[66:59]
);

    localparam int unsigned AW = $clog2(MEM_DEPTH);

    logic              e_valid_reg, e_valid_next;
    logic [15:0]       e_instr_reg;
    logic [7:0]        e_host_reg;
    logic              fwd_reg, fwd_next;
    logic [7:0]        fwd_data_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    mmie_pkg::res_t    m_res_reg;

    logic              out_free, e_fire, accept, hazard;
    logic [AW-1:0]     mem_addr;
    logic              mem_wr_en;
    logic [7:0]        mem_wr_data, mem_rd_data, mem_data;
    mmie_pkg::hz_t     hz;
    mmie_pkg::res_t    res;

    assign out_free = !m_tvalid_reg || m_tready;
    assign e_fire   = e_valid_reg && out_free;
    // the read address of the incoming request is not known until this one retires
    assign hazard   = e_valid_reg && hz.writes_addr && (s_tdata[15:12] == mmie_pkg::SRC_MEM);
    assign s_tready = (!e_valid_reg || e_fire) && !hazard;
    assign accept   = s_tvalid && s_tready;

    assign e_valid_next  = accept ? 1'b1 : (e_fire ? 1'b0 : e_valid_reg);
    assign fwd_next      = accept ? (e_fire && mem_wr_en) : (e_fire ? 1'b0 : fwd_reg);
    assign m_tvalid_next = e_fire ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    assign mem_data      = fwd_reg ? fwd_data_reg : mem_rd_data;

    mmie_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_addr),
        .wr_data (mem_wr_data),
        .rd_en   (accept),
        .rd_addr (mem_addr),
        .rd_data (mem_rd_data)
    );

    mmie_core #(
        .MEM_DEPTH (MEM_DEPTH),
        .AW        (AW)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .exec_en     (e_fire),
        .instruction (e_instr_reg),
        .host_in     (e_host_reg),
        .mem_data    (mem_data),
        .mem_addr    (mem_addr),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_data (mem_wr_data),
        .hz          (hz),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg  <= 1'b0;
            fwd_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg  <= e_valid_next;
            fwd_reg      <= fwd_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_instr_reg  <= s_tdata[15:0];
            e_host_reg   <= s_tdata[23:16];
            fwd_data_reg <= mem_wr_data;
        end
        if (e_fire)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(mmie_pkg::OUT_W - $bits(mmie_pkg::res_t))'(0), m_res_reg};

    `ASSERT_IMP(a_hazard_stall, clk, rst_n, hazard, !s_tready)
    `ASSERT_IMP(a_write_on_exec, clk, rst_n, mem_wr_en, e_fire)
    `ASSERT_IMP(a_fwd_needs_exec, clk, rst_n, fwd_reg, e_valid_reg)
    `ASSERT_NXT(a_exec_holds, clk, rst_n, e_valid_reg && !out_free, e_valid_reg && $stable(e_instr_reg))

endmodule

@@ src/mmie_mem.sv @@
// Byte-wide data memory, one write and one registered read port.
module mmie_mem #(
    parameter int unsigned DEPTH = 524288,
    parameter int unsigned AW    = 19
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/mmie_core.sv @@
// Architectural registers and execute logic of the move machine.
module mmie_core #(
    parameter int unsigned MEM_DEPTH = 524288,
    parameter int unsigned AW        = 19
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              exec_en,
    input  logic [15:0]       instruction,
    input  logic [7:0]        host_in,
    input  logic [7:0]        mem_data,
    output logic [AW-1:0]     mem_addr,
    output logic              mem_wr_en,
    output logic [7:0]        mem_wr_data,
    output mmie_pkg::hz_t     hz,
    output mmie_pkg::res_t    res
);

    localparam logic [21:0] D1 = 22'(MEM_DEPTH);
    localparam logic [21:0] D2 = 22'(2 * MEM_DEPTH);
    localparam logic [21:0] D4 = 22'(4 * MEM_DEPTH);

    logic [15:0] pc_reg, pc_next;
    logic [7:0]  a_reg, a_next;
    logic [7:0]  b_reg, b_next;
    logic [7:0]  ptr_low_reg, ptr_low_next;
    logic [7:0]  ptr_high_reg, ptr_high_next;
    logic [2:0]  seg_reg, seg_next;
    logic [7:0]  host_out_reg, host_out_next;
    logic [7:0]  audio_reg, audio_next;
    logic [7:0]  cop_data_reg, cop_data_next;
    logic [7:0]  cop_result_reg, cop_result_next;

    logic [7:0]  op, opnd, alu, v;
    logic [3:0]  src, dst;
    logic [15:0] ptr_word, pc_inc;
    logic [2:0]  idx;
    logic        in_window, host_win, cop_win, generic;
    logic [21:0] a0, a1, a2, a3;

    assign op       = instruction[15:8];
    assign opnd     = instruction[7:0];
    assign src      = op[7:4];
    assign dst      = op[3:0];
    assign alu      = (opnd == mmie_pkg::ALU_SUB_SEL) ? (a_reg - b_reg) : (a_reg + b_reg);
    assign ptr_word = {ptr_high_reg, ptr_low_reg};
    assign pc_inc   = pc_reg + 16'd1;
    assign idx      = ptr_low_reg[2:0];
    assign in_window = (ptr_high_reg == 8'd0) && ((ptr_low_reg & mmie_pkg::WIN_MASK) == 8'd0);
    assign host_win = in_window && (seg_reg == mmie_pkg::SEG_HOST);
    assign cop_win  = in_window && (seg_reg == mmie_pkg::SEG_COP);
    assign generic  = (op != mmie_pkg::OP_SEG) && (op != mmie_pkg::OP_NOP) &&
                      (op != mmie_pkg::OP_JMP) && (op != mmie_pkg::OP_JZ);

    // {seg, ptr} folded into the memory, value stays below 8 * MEM_DEPTH
    always_comb
    begin
        a0 = {3'd0, seg_reg, ptr_high_reg, ptr_low_reg};
        a1 = (a0 >= D4) ? (a0 - D4) : a0;
        a2 = (a1 >= D2) ? (a1 - D2) : a1;
        a3 = (a2 >= D1) ? (a2 - D1) : a2;
    end

    assign mem_addr = a3[AW-1:0];

    // move source
    always_comb
    begin
        v = 8'd0;
        unique case (src)
            mmie_pkg::SRC_IMM:   v = opnd;
            mmie_pkg::SRC_ALU:   v = alu;
            mmie_pkg::SRC_MEM:
            begin
                if (cop_win)
                begin
                    v = (idx == mmie_pkg::COP_IDX_ID)  ? mmie_pkg::COP_ID :
                        (idx == mmie_pkg::COP_IDX_RES) ? cop_result_reg : 8'd0;
                end
                else if (host_win)
                begin
                    v = (idx == mmie_pkg::HOST_IDX_OUT) ? host_out_reg :
                        (idx == mmie_pkg::HOST_IDX_IN)  ? host_in : mmie_pkg::HOST_STATUS;
                end
                else
                begin
                    v = mem_data;
                end
            end
            mmie_pkg::SRC_AUDIO: v = audio_reg;
            default:             v = 8'd0;
        endcase
    end

    always_comb
    begin
        pc_next         = pc_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        ptr_low_next    = ptr_low_reg;
        ptr_high_next   = ptr_high_reg;
        seg_next        = seg_reg;
        host_out_next   = host_out_reg;
        audio_next      = audio_reg;
        cop_data_next   = cop_data_reg;
        cop_result_next = cop_result_reg;
        unique case (op)
            mmie_pkg::OP_SEG:
            begin
                seg_next = opnd[2:0];
                pc_next  = pc_inc;
            end
            mmie_pkg::OP_NOP: pc_next = pc_inc;
            mmie_pkg::OP_JMP: pc_next = ptr_word;
            mmie_pkg::OP_JZ:  pc_next = (alu == 8'd0) ? ptr_word : pc_inc;
            default:
            begin
                pc_next = pc_inc;
                unique case (dst)
                    mmie_pkg::DST_A:     a_next = v;
                    mmie_pkg::DST_PL:    ptr_low_next = v;
                    mmie_pkg::DST_PH:    ptr_high_next = v;
                    mmie_pkg::DST_B:     b_next = v;
                    mmie_pkg::DST_AUDIO: audio_next = v;
                    mmie_pkg::DST_MEM:
                    begin
                        if (cop_win)
                        begin
                            if (idx == mmie_pkg::COP_IDX_DATA)
                            begin
                                cop_data_next = v;
                            end
                            else if (idx == mmie_pkg::COP_IDX_CMD)
                            begin
                                cop_result_next = ~cop_data_reg;
                            end
                        end
                        else if (host_win && (idx == mmie_pkg::HOST_IDX_OUT))
                        begin
                            host_out_next = v;
                        end
                    end
                    default: ;
                endcase
            end
        endcase
    end

    assign mem_wr_en   = exec_en && generic && (dst == mmie_pkg::DST_MEM) && !cop_win && !host_win;
    assign mem_wr_data = v;

    assign hz.writes_addr = (op == mmie_pkg::OP_SEG) ||
                            (generic && ((dst == mmie_pkg::DST_PL) || (dst == mmie_pkg::DST_PH)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            ptr_low_reg    <= '0;
            ptr_high_reg   <= '0;
            seg_reg        <= '0;
            host_out_reg   <= '0;
            audio_reg      <= '0;
            cop_data_reg   <= '0;
            cop_result_reg <= '0;
        end
        else if (exec_en)
        begin
            pc_reg         <= pc_next;
            a_reg          <= a_next;
            b_reg          <= b_next;
            ptr_low_reg    <= ptr_low_next;
            ptr_high_reg   <= ptr_high_next;
            seg_reg        <= seg_next;
            host_out_reg   <= host_out_next;
            audio_reg      <= audio_next;
            cop_data_reg   <= cop_data_next;
            cop_result_reg <= cop_result_next;
        end
    end

    assign res.next_pc        = pc_next;
    assign res.a_value        = a_next;
    assign res.b_value        = b_next;
    assign res.pointer_low    = ptr_low_next;
    assign res.pointer_high   = ptr_high_next;
    assign res.segment_value  = seg_next;
    assign res.audio_value    = audio_next;
    assign res.host_out_value = host_out_next;

endmodule

@@ sim/executor_checker.sv @@
// Checker for the move machine executor: predicts each state request and compares results.
module executor_checker #(
    parameter int unsigned MEM_DEPTH = 524288
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [mmie_pkg::IN_W-1:0]  s_tdata,   // instruction[15:0], host_in[23:16]
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [mmie_pkg::OUT_W-1:0] m_tdata,   // next_pc, a, b, pointer, segment, audio, host_out
    output int                         outstanding,
    output int                         fail_count
);

    logic [15:0]    pc;
    logic [7:0]     acc;
    logic [7:0]     breg;
    logic [7:0]     ptr_lo;
    logic [7:0]     ptr_hi;
    logic [2:0]     seg;
    logic [7:0]     audio;
    logic [7:0]     host_out;
    logic [7:0]     cop_data;
    logic [7:0]     cop_result;
    logic [7:0]     data_bytes [int unsigned];
    mmie_pkg::res_t expected_states [$];
    int             failures = 0;

    assign fail_count = failures;

    function automatic void check_field(string name, int unsigned want, int unsigned seen);
        if (want != seen)
        begin
            $error("%s: expected %h, got %h", name, want, seen);
            failures++;
        end
    endfunction

    // executes one instruction on the predicted machine state
    function automatic mmie_pkg::res_t execute_instruction(logic [15:0] instr,
                                                           logic [7:0] host_byte);
        logic [7:0]     opc;
        logic [7:0]     opnd;
        logic [7:0]     alu;
        logic [7:0]     v;
        logic [3:0]     src;
        logic [3:0]     dst;
        logic [2:0]     idx;
        logic           in_win;
        logic           host_win;
        logic           cop_win;
        int unsigned    addr;
        mmie_pkg::res_t r;
        opc = instr[15:8];
        opnd = instr[7:0];
        src = opc[7:4];
        dst = opc[3:0];
        alu = (opnd == mmie_pkg::ALU_SUB_SEL) ? acc - breg : acc + breg;
        in_win = (ptr_hi == 8'h00) && ((ptr_lo & mmie_pkg::WIN_MASK) == 8'h00);
        host_win = in_win && (seg == mmie_pkg::SEG_HOST);
        cop_win = in_win && (seg == mmie_pkg::SEG_COP);
        idx = ptr_lo[2:0];
        addr = {seg, ptr_hi, ptr_lo} % MEM_DEPTH;
        v = 8'h00;
        case (opc)
            mmie_pkg::OP_SEG:
            begin
                seg = opnd[2:0];
                pc = pc + 16'd1;
            end
            mmie_pkg::OP_NOP: pc = pc + 16'd1;
            mmie_pkg::OP_JMP: pc = {ptr_hi, ptr_lo};
            mmie_pkg::OP_JZ:  pc = (alu == 8'h00) ? {ptr_hi, ptr_lo} : pc + 16'd1;
            default:
            begin
                case (src)
                    mmie_pkg::SRC_IMM: v = opnd;
                    mmie_pkg::SRC_ALU: v = alu;
                    mmie_pkg::SRC_MEM:
                    begin
                        if (cop_win)
                            v = (idx == mmie_pkg::COP_IDX_ID) ? mmie_pkg::COP_ID :
                                (idx == mmie_pkg::COP_IDX_RES) ? cop_result : 8'h00;
                        else if (host_win)
                            v = (idx == mmie_pkg::HOST_IDX_OUT) ? host_out :
                                (idx == mmie_pkg::HOST_IDX_IN) ? host_byte :
                                mmie_pkg::HOST_STATUS;
                        else if (data_bytes.exists(addr))
                            v = data_bytes[addr];
                    end
                    mmie_pkg::SRC_AUDIO: v = audio;
                    default: v = 8'h00;
                endcase
                case (dst)
                    mmie_pkg::DST_A:     acc = v;
                    mmie_pkg::DST_PL:    ptr_lo = v;
                    mmie_pkg::DST_PH:    ptr_hi = v;
                    mmie_pkg::DST_B:     breg = v;
                    mmie_pkg::DST_AUDIO: audio = v;
                    mmie_pkg::DST_MEM:
                    begin
                        if (cop_win)
                        begin
                            if (idx == mmie_pkg::COP_IDX_DATA)
                                cop_data = v;
                            else if (idx == mmie_pkg::COP_IDX_CMD)
                                cop_result = ~cop_data;
                        end
                        else if (host_win)
                        begin
                            if (idx == mmie_pkg::HOST_IDX_OUT)
                                host_out = v;
                        end
                        else
                            data_bytes[addr] = v;
                    end
                    default: ;
                endcase
                pc = pc + 16'd1;
            end
        endcase
        r.next_pc = pc;
        r.a_value = acc;
        r.b_value = breg;
        r.pointer_low = ptr_lo;
        r.pointer_high = ptr_hi;
        r.segment_value = seg;
        r.audio_value = audio;
        r.host_out_value = host_out;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mmie_pkg::res_t got;
        mmie_pkg::res_t want;
        if (!rst_n)
        begin
            pc = '0;
            acc = '0;
            breg = '0;
            ptr_lo = '0;
            ptr_hi = '0;
            seg = '0;
            audio = '0;
            host_out = '0;
            cop_data = '0;
            cop_result = '0;
            data_bytes.delete();
            expected_states.delete();
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_states.push_back(execute_instruction(s_tdata[15:0], s_tdata[23:16]));
            if (m_tvalid && m_tready)
            begin
                got = mmie_pkg::res_t'(m_tdata[$bits(mmie_pkg::res_t)-1:0]);
                if (expected_states.size() == 0)
                begin
                    $error("state request with no instruction pending: %h", m_tdata);
                    failures++;
                end
                else
                begin
                    want = expected_states.pop_front();
                    check_field("next_pc", want.next_pc, got.next_pc);
                    check_field("a_value", want.a_value, got.a_value);
                    check_field("b_value", want.b_value, got.b_value);
                    check_field("pointer_low", want.pointer_low, got.pointer_low);
                    check_field("pointer_high", want.pointer_high, got.pointer_high);
                    check_field("segment_value", want.segment_value, got.segment_value);
                    check_field("audio_value", want.audio_value, got.audio_value);
                    check_field("host_out_value", want.host_out_value, got.host_out_value);
                end
            end
            outstanding <= expected_states.size();
        end
    end

endmodule

@@ sim/testbench.sv @@
// Testbench top: drives instruction requests into the executor and gives the verdict.
module testbench;

    localparam int RANDOM_ITEMS = 1800;
    localparam int IDLE_LIMIT   = 4000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [mmie_pkg::IN_W-1:0]  s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [mmie_pkg::OUT_W-1:0] m_tdata;
    int                         outstanding;
    int                         fail_count;
    int                         idle_cycles = 0;
    int                         burst_left = 0;

    // what the stimulus knows of the address, so that no unwritten byte is read
    logic [2:0]      seg_track = '0;
    logic [7:0]      pl_track = '0;
    logic [7:0]      ph_track = '0;
    logic            pl_known = 1'b1;
    logic            ph_known = 1'b1;
    bit              written [int unsigned];
    int unsigned     written_addrs [$];
    logic [15:0]     planned_words [$];

    move_machine_instruction_executor_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    executor_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready)))
                idle_cycles++;
            else
                idle_cycles = 0;
        end
        $display("Regression FAIL");
        $finish;
    end

    // receiver: stretches of steady, light, heavy and very heavy back-pressure
    initial
    begin
        int mode;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(16, 160))
            begin
                @(posedge clk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 1) == 0);
                    default: m_tready <= ($urandom_range(0, 11) == 0);
                endcase
            end
        end
    end

    function automatic logic [18:0] cur_addr();
        return {seg_track, ph_track, pl_track};
    endfunction

    function automatic bit is_move(logic [7:0] opc);
        return !(opc inside {mmie_pkg::OP_SEG, mmie_pkg::OP_NOP,
                             mmie_pkg::OP_JMP, mmie_pkg::OP_JZ});
    endfunction

    function automatic bit in_window();
        return pl_known && ph_known && ph_track == 8'h00 &&
               (pl_track & mmie_pkg::WIN_MASK) == 8'h00 &&
               (seg_track == mmie_pkg::SEG_HOST || seg_track == mmie_pkg::SEG_COP);
    endfunction

    function automatic void note_word(logic [15:0] w);
        if (w[15:8] == mmie_pkg::OP_SEG)
            seg_track = w[2:0];
        else if (is_move(w[15:8]))
        begin
            case (w[11:8])
                mmie_pkg::DST_PL:
                begin
                    pl_known = (w[15:12] == mmie_pkg::SRC_IMM);
                    pl_track = w[7:0];
                end
                mmie_pkg::DST_PH:
                begin
                    ph_known = (w[15:12] == mmie_pkg::SRC_IMM);
                    ph_track = w[7:0];
                end
                mmie_pkg::DST_MEM:
                    if (pl_known && ph_known && !in_window() && !written.exists(cur_addr()))
                    begin
                        written[cur_addr()] = 1'b1;
                        written_addrs.push_back(cur_addr());
                    end
                default: ;
            endcase
        end
    endfunction

    // a load whose address is unknown or unwritten gets another source
    function automatic logic [15:0] sanitize(logic [15:0] w);
        logic [3:0] src;
        if (is_move(w[15:8]) && w[15:12] == mmie_pkg::SRC_MEM &&
            !(in_window() || (pl_known && ph_known && written.exists(cur_addr()))))
        begin
            src = 4'($urandom_range(0, 14));
            if (src >= mmie_pkg::SRC_MEM)
                src = src + 4'd1;
            w[15:12] = src;
        end
        return w;
    endfunction

    function automatic logic [15:0] rand_access();
        if ($urandom_range(0, 1))
            return {mmie_pkg::SRC_MEM, 4'($urandom), 8'($urandom)};
        return {4'($urandom), mmie_pkg::DST_MEM, 8'($urandom)};
    endfunction

    function automatic logic [15:0] rand_register_op();
        logic [7:0] opnd;
        logic [3:0] src;
        logic [3:0] dst;
        opnd = ($urandom_range(0, 3) == 0) ? mmie_pkg::ALU_SUB_SEL : 8'($urandom);
        case ($urandom_range(0, 2))
            0: src = mmie_pkg::SRC_IMM;
            1: src = mmie_pkg::SRC_ALU;
            default: src = 4'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: dst = mmie_pkg::DST_A;
            1: dst = mmie_pkg::DST_B;
            2: dst = mmie_pkg::DST_AUDIO;
            default: dst = 4'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0: return {mmie_pkg::OP_JZ, opnd};
            1: return {mmie_pkg::OP_JMP, opnd};
            2: return {mmie_pkg::OP_NOP, opnd};
            default: return {src, dst, opnd};
        endcase
    endfunction

    function automatic void plan_sequence();
        int unsigned kind;
        logic [18:0] a;
        logic [7:0]  x;
        bit          sub;
        kind = $urandom_range(0, 99);
        if (kind < 20 && written_addrs.size() > 0)
        begin
            // revisit a stored byte
            a = 19'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
            planned_words.push_back({mmie_pkg::OP_SEG, 5'($urandom), a[18:16]});
            planned_words.push_back({mmie_pkg::SRC_IMM, mmie_pkg::DST_PL, a[7:0]});
            planned_words.push_back({mmie_pkg::SRC_IMM, mmie_pkg::DST_PH, a[15:8]});
            repeat ($urandom_range(1, 3))
                planned_words.push_back(rand_access());
        end
        else if (kind < 45)
        begin
            // host or coprocessor window traffic
            planned_words.push_back({mmie_pkg::OP_SEG, 5'($urandom),
                                     ($urandom_range(0, 1) ? mmie_pkg::SEG_HOST
                                                           : mmie_pkg::SEG_COP)});
            planned_words.push_back({mmie_pkg::SRC_IMM, mmie_pkg::DST_PH, 8'h00});
            repeat ($urandom_range(2, 6))
            begin
                planned_words.push_back({mmie_pkg::SRC_IMM, mmie_pkg::DST_PL,
                                         5'd0, 3'($urandom)});
                planned_words.push_back(rand_access());
            end
        end
        else if (kind < 65)
        begin
            // store to a random place, do some work, load it back
            planned_words.push_back({mmie_pkg::OP_SEG, 8'($urandom)});
            planned_words.push_back({mmie_pkg::SRC_IMM, mmie_pkg::DST_PL, 8'($urandom)});
            planned_words.push_back({mmie_pkg::SRC_IMM, mmie_pkg::DST_PH, 8'($urandom)});
            planned_words.push_back({4'($urandom), mmie_pkg::DST_MEM, 8'($urandom)});
            repeat ($urandom_range(0, 3))
                planned_words.push_back(rand_register_op());
            planned_words.push_back({mmie_pkg::SRC_MEM, 4'($urandom), 8'($urandom)});
        end
        else if (kind < 88)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                // force a taken conditional jump
                x = 8'($urandom);
                sub = $urandom_range(0, 1);
                planned_words.push_back({mmie_pkg::SRC_IMM, mmie_pkg::DST_A, x});
                planned_words.push_back({mmie_pkg::SRC_IMM, mmie_pkg::DST_B,
                                         (sub ? x : 8'(8'd0 - x))});
                planned_words.push_back({mmie_pkg::OP_JZ,
                                         (sub ? mmie_pkg::ALU_SUB_SEL : 8'h00)});
            end
            repeat ($urandom_range(2, 6))
                planned_words.push_back(rand_register_op());
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                planned_words.push_back(16'($urandom));
        end
    endfunction

    task automatic send_word(logic [15:0] w, logic [7:0] host);
        note_word(w);
        s_tdata <= {host, w};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] w;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(16'h0000, 8'h00);
        send_word({mmie_pkg::SRC_IMM, mmie_pkg::DST_A, 8'h05}, 8'($urandom));
        send_word({mmie_pkg::SRC_IMM, mmie_pkg::DST_B, 8'hFF}, 8'($urandom));
        send_word({mmie_pkg::SRC_ALU, mmie_pkg::DST_A, mmie_pkg::ALU_SUB_SEL}, 8'($urandom));
        send_word({mmie_pkg::SRC_ALU, mmie_pkg::DST_B, 8'h80}, 8'($urandom));
        // host window: status, input byte and output register
        send_word({mmie_pkg::OP_SEG, 8'hFB}, 8'($urandom));
        send_word({mmie_pkg::SRC_IMM, mmie_pkg::DST_MEM, 8'h5A}, 8'($urandom));
        send_word({mmie_pkg::SRC_MEM, mmie_pkg::DST_A, 8'h00}, 8'($urandom));
        send_word({mmie_pkg::SRC_IMM, mmie_pkg::DST_PL, 8'h01}, 8'($urandom));
        send_word({mmie_pkg::SRC_MEM, mmie_pkg::DST_B, 8'h00}, 8'hC3);
        send_word({mmie_pkg::SRC_IMM, mmie_pkg::DST_PL, 8'h07}, 8'($urandom));
        send_word({mmie_pkg::SRC_MEM, mmie_pkg::DST_AUDIO, 8'h00}, 8'($urandom));
        // coprocessor window: id, data, command, result
        send_word({mmie_pkg::OP_SEG, 8'h04}, 8'($urandom));
        send_word({mmie_pkg::SRC_IMM, mmie_pkg::DST_PL, 8'h00}, 8'($urandom));
        send_word({mmie_pkg::SRC_MEM, mmie_pkg::DST_A, 8'h00}, 8'($urandom));
        send_word({mmie_pkg::SRC_IMM, mmie_pkg::DST_PL, 8'h02}, 8'($urandom));
        send_word({mmie_pkg::SRC_IMM, mmie_pkg::DST_MEM, 8'h3C}, 8'($urandom));
        send_word({mmie_pkg::SRC_IMM, mmie_pkg::DST_PL, 8'h03}, 8'($urandom));
        send_word({mmie_pkg::SRC_AUDIO, mmie_pkg::DST_MEM, 8'h00}, 8'($urandom));
        send_word({mmie_pkg::SRC_IMM, mmie_pkg::DST_PL, 8'h05}, 8'($urandom));
        send_word({mmie_pkg::SRC_MEM, mmie_pkg::DST_B, 8'h00}, 8'($urandom));
        // top byte of memory, then jumps and the PC wrap
        send_word({mmie_pkg::OP_SEG, 8'h07}, 8'($urandom));
        send_word({mmie_pkg::SRC_IMM, mmie_pkg::DST_PH, 8'hFF}, 8'($urandom));
        send_word({mmie_pkg::SRC_IMM, mmie_pkg::DST_PL, 8'hFF}, 8'($urandom));
        send_word({mmie_pkg::SRC_ALU, mmie_pkg::DST_MEM, mmie_pkg::ALU_SUB_SEL}, 8'($urandom));
        send_word({mmie_pkg::SRC_MEM, mmie_pkg::DST_A, 8'h00}, 8'($urandom));
        send_word({mmie_pkg::OP_JMP, 8'h00}, 8'($urandom));
        send_word(16'hFFFF, 8'hFF);
        send_word({mmie_pkg::OP_JZ, 8'h00}, 8'($urandom));
        send_word({mmie_pkg::OP_JZ, mmie_pkg::ALU_SUB_SEL}, 8'($urandom));
        send_word({4'h2, mmie_pkg::DST_A, 8'hFF}, 8'($urandom));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                drain();
            if (planned_words.size() == 0)
                plan_sequence();
            w = sanitize(planned_words.pop_front());
            send_word(w, 8'($urandom));
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
